// ===== src/led_fade_pulse_controller_core_macros.svh =====
// ----------------------------------------------------------------------------
// LED fade controller assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LED_FADE_PULSE_CONTROLLER_CORE_MACROS_SVH
`define LED_FADE_PULSE_CONTROLLER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LFPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LFPC_ASSERT(lbl, prop, msg)
`define LFPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/lfpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpc_pkg
// Shared types and constants of the LED fade / pulse controller.
// ----------------------------------------------------------------------------
package lfpc_pkg;

  localparam int TIME_BITS   = 16;
  localparam int LEVEL_W     = 8;
  localparam int DUR_W       = 16;
  localparam int MODE_W      = 2;
  localparam int CMD_W       = 3;
  localparam int ADV_W       = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * LEVEL_W - 2;

  // signed level difference times signed time offset
  localparam int OPA_W       = LEVEL_W + 1;
  localparam int OPB_W       = TIME_BITS + 1;
  localparam int PROD_W      = OPA_W + OPB_W;
  localparam int DIV_NUM_W   = LEVEL_W + TIME_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

  // mode register codes
  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PULSE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOFT   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_LVL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_HOLD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_HOLD = 3'd6;

  // register reset values
  localparam logic [MODE_W-1:0]  MODE_RST     = MODE_NORMAL;
  localparam logic [LEVEL_W-1:0] ON_LEVEL_RST = 8'd255;
  localparam logic [LEVEL_W-1:0] OFF_LVL_RST  = 8'd0;
  localparam logic [DUR_W-1:0]   FADE_RST     = 16'd500;
  localparam logic [DUR_W-1:0]   HOLD_RST     = 16'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_SWITCH_ON  = 3'd1,
    CMD_SWITCH_OFF = 3'd2,
    CMD_ENABLE     = 3'd3,
    CMD_DISABLE    = 3'd4,
    CMD_NOP        = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    PH_OFF      = 2'd0,
    PH_FADE_IN  = 2'd1,
    PH_ON       = 2'd2,
    PH_FADE_OUT = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    JOB_FADE_IN,
    JOB_FADE_OUT,
    JOB_SWITCH_OFF
  } job_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV_START,
    BK_DIV_WAIT,
    BK_FINISH
  } back_state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [ADV_W-1:0] adv;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/lfpc_front.sv =====
// ----------------------------------------------------------------------------
// lfpc_front
// Input side: unpacks the stream word, decodes the command, feeds the queue.
// ----------------------------------------------------------------------------
module lfpc_front (
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lfpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  lfpc_pkg::queue_stat_t            qstat_i,
  output logic                             push_o,
  output lfpc_pkg::item_t                  item_o
);

  logic [lfpc_pkg::CMD_W-1:0] raw_cmd;

  assign raw_cmd       = s_axis_tdata[lfpc_pkg::CMD_W-1:0];
  assign s_axis_tready = !qstat_i.full;
  assign push_o        = s_axis_tvalid && !qstat_i.full;

  always_comb begin
    item_o.adv = s_axis_tdata[lfpc_pkg::CMD_W +: lfpc_pkg::ADV_W];
    // undefined command codes still return a result, with no state change
    if (raw_cmd <= lfpc_pkg::CMD_W'(lfpc_pkg::CMD_DISABLE)) begin
      item_o.cmd = lfpc_pkg::cmd_e'(raw_cmd);
    end else begin
      item_o.cmd = lfpc_pkg::CMD_NOP;
    end
  end

endmodule

// ===== src/lfpc_queue.sv =====
// ----------------------------------------------------------------------------
// lfpc_queue
// Short FIFO of decoded items between the input side and the executor.
// ----------------------------------------------------------------------------
module lfpc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lfpc_pkg::item_t       item_i,
  input  logic                  pop_i,
  output lfpc_pkg::item_t       item_o,
  output lfpc_pkg::queue_stat_t stat_o
);

  lfpc_pkg::item_t                  mem_q [lfpc_pkg::QUEUE_DEPTH];
  logic [lfpc_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [lfpc_pkg::QCNT_W-1:0]      cnt_q;

  assign stat_o.full  = (cnt_q == lfpc_pkg::QCNT_W'(lfpc_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/lfpc_div.sv =====
// ----------------------------------------------------------------------------
// lfpc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfpc_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [lfpc_pkg::DIV_NUM_W-1:0]     num_i,
  input  logic [lfpc_pkg::DUR_W-1:0]         den_i,
  output lfpc_pkg::div_stat_t                stat_o,
  output logic [lfpc_pkg::DIV_NUM_W-1:0]     quo_o
);

  logic                              busy_q, done_q;
  logic [lfpc_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [lfpc_pkg::DUR_W-1:0]        rem_q, rem_d;
  logic [lfpc_pkg::DIV_NUM_W-1:0]    quo_q;
  logic [lfpc_pkg::DUR_W:0]          shifted;
  logic                              fits;

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

  always_comb begin
    shifted = {rem_q, quo_q[lfpc_pkg::DIV_NUM_W-1]};
    fits    = (shifted >= {1'b0, den_i});
    if (fits) begin
      rem_d = lfpc_pkg::DUR_W'(shifted - {1'b0, den_i});
    end else begin
      rem_d = shifted[lfpc_pkg::DUR_W-1:0];
    end
  end

  // numerator shifts out of the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[lfpc_pkg::DIV_NUM_W-2:0], fits};
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= lfpc_pkg::DIV_CNT_W'(lfpc_pkg::DIV_NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == lfpc_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

endmodule

// ===== src/lfpc_exec.sv =====
// ----------------------------------------------------------------------------
// lfpc_exec
// Executor: holds registers and fade state, runs each command, drives results.
// ----------------------------------------------------------------------------
module lfpc_exec (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lfpc_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [lfpc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  lfpc_pkg::item_t                    item_i,
  input  lfpc_pkg::queue_stat_t              qstat_i,
  output logic                               pop_o,
  output logic                               div_start_o,
  output logic [lfpc_pkg::DIV_NUM_W-1:0]     div_num_o,
  output logic [lfpc_pkg::DUR_W-1:0]         div_den_o,
  input  lfpc_pkg::div_stat_t                div_stat_i,
  input  logic [lfpc_pkg::DIV_NUM_W-1:0]     div_quo_i,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lfpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int TB = lfpc_pkg::TIME_BITS;
  localparam int LW = lfpc_pkg::LEVEL_W;
  localparam int PW = lfpc_pkg::PROD_W;

  lfpc_pkg::back_state_e state_q, state_d;

  // configuration
  logic [lfpc_pkg::MODE_W-1:0] mode_q;
  logic [LW-1:0]               on_lvl_q, off_lvl_q;
  logic [lfpc_pkg::DUR_W-1:0]  fade_in_q, fade_out_q, on_hold_q, off_hold_q;

  // controller state
  logic                        en_q, sw_q;
  lfpc_pkg::phase_e            phase_q;
  logic [TB-1:0]               elapsed_q;
  logic [LW-1:0]               level_q;

  // job registers
  lfpc_pkg::job_e              job_q;
  logic                        fast_q;
  logic signed [lfpc_pkg::OPA_W-1:0] mul_a_q;
  logic signed [lfpc_pkg::OPB_W-1:0] mul_b_q;
  logic [lfpc_pkg::DUR_W-1:0]  div_den_q;
  logic                        den_neg_q, quo_neg_q;
  logic signed [PW-1:0]        prod_q;

  logic                        m_valid_q;
  logic [lfpc_pkg::OUT_TDATA_W-1:0] m_data_q;

  // decode
  logic                        out_free, job_need, job_fast, job_start, commit;
  lfpc_pkg::job_e              job_kind;
  logic                        fading_mode;
  logic [TB:0]                 e_sum;
  logic [TB-1:0]               e1;
  logic signed [LW:0]          diff_lvl;
  logic [LW:0]                 diff_abs;
  logic signed [lfpc_pkg::OPA_W-1:0] op_a;
  logic signed [lfpc_pkg::OPB_W-1:0] op_b;
  logic [lfpc_pkg::DUR_W-1:0]  op_den;
  logic [PW-1:0]               prod_abs;

  // finish arithmetic
  logic signed [PW-1:0]        q_s;
  logic signed [PW:0]          fade_sum, sw_diff;
  logic [LW-1:0]               lvl_lo, lvl_hi, fade_clamp, fade_val;
  logic [TB-1:0]               sw_dt;

  // next state of the controller
  logic                        nx_en, nx_sw;
  lfpc_pkg::phase_e            nx_phase;
  logic [TB-1:0]               nx_elapsed;
  logic [LW-1:0]               nx_level, nx_lv;

  assign out_free    = !m_valid_q || m_axis_tready;
  assign fading_mode = (mode_q == lfpc_pkg::MODE_PULSE) || (mode_q == lfpc_pkg::MODE_SOFT);
  assign e_sum       = {1'b0, elapsed_q} + (TB + 1)'(item_i.adv);
  assign e1          = e_sum[TB] ? '1 : e_sum[TB-1:0];
  assign diff_lvl    = $signed({1'b0, on_lvl_q}) - $signed({1'b0, off_lvl_q});
  assign diff_abs    = diff_lvl[LW] ? (LW + 1)'(-diff_lvl) : diff_lvl;
  assign prod_abs    = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
  assign div_num_o   = prod_abs[lfpc_pkg::DIV_NUM_W-1:0];
  assign div_den_o   = div_den_q;

  // which items need the divider
  always_comb begin
    job_need = 1'b0;
    job_kind = lfpc_pkg::JOB_FADE_IN;
    job_fast = 1'b0;
    if (item_i.cmd == lfpc_pkg::CMD_TICK && en_q && fading_mode) begin
      if (phase_q == lfpc_pkg::PH_FADE_IN) begin
        job_need = 1'b1;
        job_kind = lfpc_pkg::JOB_FADE_IN;
        job_fast = (fade_in_q == '0);
      end else if (phase_q == lfpc_pkg::PH_FADE_OUT) begin
        job_need = 1'b1;
        job_kind = lfpc_pkg::JOB_FADE_OUT;
        job_fast = (fade_out_q == '0);
      end
    end else if (item_i.cmd == lfpc_pkg::CMD_SWITCH_OFF &&
                 phase_q == lfpc_pkg::PH_FADE_IN) begin
      job_need = 1'b1;
      job_kind = lfpc_pkg::JOB_SWITCH_OFF;
      job_fast = (diff_lvl == '0);
    end
  end

  always_comb begin
    case (job_kind)
      lfpc_pkg::JOB_FADE_OUT: begin
        op_a   = diff_lvl;
        op_b   = $signed({1'b0, fade_out_q}) - $signed({1'b0, e1});
        op_den = fade_out_q;
      end
      lfpc_pkg::JOB_SWITCH_OFF: begin
        op_a   = $signed({1'b0, level_q}) - $signed({1'b0, off_lvl_q});
        op_b   = $signed({1'b0, fade_out_q});
        op_den = lfpc_pkg::DUR_W'(diff_abs);
      end
      default: begin
        op_a   = diff_lvl;
        op_b   = $signed({1'b0, e1});
        op_den = fade_in_q;
      end
    endcase
  end

  // FSM next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfpc_pkg::BK_IDLE: begin
        if (job_start) begin
          state_d = job_fast ? lfpc_pkg::BK_FINISH : lfpc_pkg::BK_MUL;
        end
      end
      lfpc_pkg::BK_MUL:       state_d = lfpc_pkg::BK_DIV_START;
      lfpc_pkg::BK_DIV_START: state_d = lfpc_pkg::BK_DIV_WAIT;
      lfpc_pkg::BK_DIV_WAIT: begin
        if (div_stat_i.done) begin
          state_d = lfpc_pkg::BK_FINISH;
        end
      end
      lfpc_pkg::BK_FINISH:    state_d = lfpc_pkg::BK_IDLE;
      default:                state_d = lfpc_pkg::BK_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    pop_o       = (state_q == lfpc_pkg::BK_IDLE) && !qstat_i.empty && out_free;
    job_start   = pop_o && job_need;
    commit      = (pop_o && !job_need) || (state_q == lfpc_pkg::BK_FINISH);
    div_start_o = (state_q == lfpc_pkg::BK_DIV_START);
  end

  // ramp value and switch-off time from the quotient
  always_comb begin
    q_s      = quo_neg_q ? -$signed({2'b00, div_quo_i}) : $signed({2'b00, div_quo_i});
    lvl_lo   = diff_lvl[LW] ? on_lvl_q : off_lvl_q;
    lvl_hi   = diff_lvl[LW] ? off_lvl_q : on_lvl_q;
    fade_sum = $signed({{(PW + 1 - LW){1'b0}}, off_lvl_q}) + {q_s[PW-1], q_s};
    if (fade_sum > $signed({{(PW + 1 - LW){1'b0}}, lvl_hi})) begin
      fade_clamp = lvl_hi;
    end else if (fade_sum < $signed({{(PW + 1 - LW){1'b0}}, lvl_lo})) begin
      fade_clamp = lvl_lo;
    end else begin
      fade_clamp = fade_sum[LW-1:0];
    end
    if (fast_q) begin
      fade_val = (job_q == lfpc_pkg::JOB_FADE_IN) ? on_lvl_q : off_lvl_q;
    end else begin
      fade_val = fade_clamp;
    end

    sw_diff = $signed({{(PW + 1 - lfpc_pkg::DUR_W){1'b0}}, fade_out_q}) - {q_s[PW-1], q_s};
    if (fast_q) begin
      sw_dt = TB'(fade_out_q);
    end else if (sw_diff < 0) begin
      sw_dt = '0;
    end else if (sw_diff > $signed({{(PW + 1 - lfpc_pkg::DUR_W){1'b0}}, fade_out_q})) begin
      sw_dt = TB'(fade_out_q);
    end else begin
      sw_dt = sw_diff[TB-1:0];
    end
  end

  // command semantics
  always_comb begin
    nx_en      = en_q;
    nx_sw      = sw_q;
    nx_phase   = phase_q;
    nx_elapsed = elapsed_q;
    nx_level   = level_q;
    if (state_q == lfpc_pkg::BK_FINISH) begin
      case (job_q)
        lfpc_pkg::JOB_FADE_IN: begin
          nx_level = fade_val;
          if (mode_q == lfpc_pkg::MODE_PULSE) begin
            if (elapsed_q >= TB'(fade_in_q)) begin
              nx_elapsed = '0;
              nx_phase   = lfpc_pkg::PH_ON;
            end
          end else if (fade_val == on_lvl_q) begin
            nx_elapsed = '0;
            nx_phase   = lfpc_pkg::PH_ON;
          end
        end
        lfpc_pkg::JOB_FADE_OUT: begin
          nx_level = fade_val;
          if (mode_q == lfpc_pkg::MODE_PULSE) begin
            if (elapsed_q >= TB'(fade_out_q)) begin
              nx_level   = off_lvl_q;
              nx_elapsed = '0;
              nx_phase   = lfpc_pkg::PH_OFF;
            end
          end else if (fade_val == off_lvl_q) begin
            nx_elapsed = '0;
            nx_phase   = lfpc_pkg::PH_OFF;
          end
        end
        lfpc_pkg::JOB_SWITCH_OFF: begin
          nx_elapsed = sw_dt;
          nx_phase   = lfpc_pkg::PH_FADE_OUT;
          nx_sw      = 1'b0;
        end
        default: ;
      endcase
    end else begin
      case (item_i.cmd)
        lfpc_pkg::CMD_TICK: begin
          if (en_q) begin
            nx_elapsed = e1;
            case (mode_q)
              lfpc_pkg::MODE_NORMAL: begin
                nx_phase = sw_q ? lfpc_pkg::PH_ON : lfpc_pkg::PH_OFF;
                nx_level = sw_q ? on_lvl_q : off_lvl_q;
              end
              lfpc_pkg::MODE_PULSE: begin
                if (phase_q == lfpc_pkg::PH_ON) begin
                  nx_level = on_lvl_q;
                  if (e1 >= TB'(on_hold_q)) begin
                    nx_phase   = lfpc_pkg::PH_FADE_OUT;
                    nx_elapsed = '0;
                  end
                end else begin
                  nx_level = off_lvl_q;
                  if (e1 >= TB'(off_hold_q) && sw_q) begin
                    nx_phase   = lfpc_pkg::PH_FADE_IN;
                    nx_elapsed = '0;
                  end
                end
              end
              lfpc_pkg::MODE_SOFT: begin
                if (phase_q == lfpc_pkg::PH_ON) begin
                  nx_level = on_lvl_q;
                  if (!sw_q) begin
                    nx_phase   = lfpc_pkg::PH_FADE_OUT;
                    nx_elapsed = '0;
                  end
                end else begin
                  nx_level = off_lvl_q;
                  if (sw_q) begin
                    nx_phase   = lfpc_pkg::PH_FADE_IN;
                    nx_elapsed = '0;
                  end
                end
              end
              default: nx_level = '0;
            endcase
          end
        end
        lfpc_pkg::CMD_SWITCH_ON: begin
          nx_elapsed = '0;
          nx_sw      = 1'b1;
        end
        lfpc_pkg::CMD_SWITCH_OFF: begin
          if (phase_q == lfpc_pkg::PH_ON) begin
            nx_phase   = lfpc_pkg::PH_FADE_OUT;
            nx_elapsed = '0;
          end
          nx_sw = 1'b0;
        end
        lfpc_pkg::CMD_ENABLE: begin
          if (!en_q) begin
            nx_en      = 1'b1;
            nx_elapsed = '0;
            nx_phase   = lfpc_pkg::PH_OFF;
          end
        end
        lfpc_pkg::CMD_DISABLE: begin
          if (en_q) begin
            nx_en    = 1'b0;
            nx_level = '0;
          end
        end
        default: ;
      endcase
    end
    nx_lv = nx_en ? nx_level : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lfpc_pkg::BK_IDLE;
      mode_q     <= lfpc_pkg::MODE_RST;
      on_lvl_q   <= lfpc_pkg::ON_LEVEL_RST;
      off_lvl_q  <= lfpc_pkg::OFF_LVL_RST;
      fade_in_q  <= lfpc_pkg::FADE_RST;
      fade_out_q <= lfpc_pkg::FADE_RST;
      on_hold_q  <= lfpc_pkg::HOLD_RST;
      off_hold_q <= lfpc_pkg::HOLD_RST;
      en_q       <= 1'b0;
      sw_q       <= 1'b0;
      phase_q    <= lfpc_pkg::PH_OFF;
      elapsed_q  <= '0;
      level_q    <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        en_q      <= nx_en;
        sw_q      <= nx_sw;
        phase_q   <= nx_phase;
        elapsed_q <= nx_elapsed;
        level_q   <= nx_level;
        m_valid_q <= 1'b1;
      end else begin
        if (job_start && item_i.cmd == lfpc_pkg::CMD_TICK) begin
          elapsed_q <= e1;
        end
        if (m_axis_tready) begin
          m_valid_q <= 1'b0;
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          lfpc_pkg::CFG_MODE: begin
            // a mode change restarts the time base
            if (cfg_data_i[lfpc_pkg::MODE_W-1:0] != mode_q) begin
              mode_q    <= cfg_data_i[lfpc_pkg::MODE_W-1:0];
              elapsed_q <= '0;
            end
          end
          lfpc_pkg::CFG_ON_LEVEL: on_lvl_q   <= cfg_data_i[LW-1:0];
          lfpc_pkg::CFG_OFF_LVL:  off_lvl_q  <= cfg_data_i[LW-1:0];
          lfpc_pkg::CFG_FADE_IN:  fade_in_q  <= cfg_data_i[lfpc_pkg::DUR_W-1:0];
          lfpc_pkg::CFG_FADE_OUT: fade_out_q <= cfg_data_i[lfpc_pkg::DUR_W-1:0];
          lfpc_pkg::CFG_ON_HOLD:  on_hold_q  <= cfg_data_i[lfpc_pkg::DUR_W-1:0];
          lfpc_pkg::CFG_OFF_HOLD: off_hold_q <= cfg_data_i[lfpc_pkg::DUR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_start) begin
      job_q     <= job_kind;
      fast_q    <= job_fast;
      mul_a_q   <= op_a;
      mul_b_q   <= op_b;
      div_den_q <= op_den;
      den_neg_q <= (job_kind == lfpc_pkg::JOB_SWITCH_OFF) && diff_lvl[LW];
    end
    if (state_q == lfpc_pkg::BK_MUL) begin
      prod_q <= mul_a_q * mul_b_q;
    end
    if (state_q == lfpc_pkg::BK_DIV_START) begin
      quo_neg_q <= prod_q[PW-1] ^ den_neg_q;
    end
    if (commit) begin
      m_data_q <= {{lfpc_pkg::OUT_PAD_W{1'b0}}, nx_phase,
                   lfpc_pkg::LEVEL_FULL - nx_lv, nx_lv};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== src/led_fade_pulse_controller_core.sv =====
// ----------------------------------------------------------------------------
// led_fade_pulse_controller_core
// LED brightness controller with normal, soft-fade and pulsing modes.
// ----------------------------------------------------------------------------
// Input stream carries one command per item: tick with elapsed milliseconds,
// switch on, switch off, enable or disable. Every item returns exactly one
// result item: level, active-low PWM compare (255 - level) and phase.
// Registers are written through cfg_we_i / cfg_addr_i / cfg_data_i; the user
// must do so only while the block is idle, which the block does not enforce.
// Mode, levels, fade and hold times take effect on later items. Items enter a
// two-entry queue; the executor pulls one when idle with its output register
// free or being drained. A tick during a fade, or a switch off during a
// fade-in, goes through a 9x17 multiply and a 24-bit serial divider, unless
// its fade time or level span is zero; no new item is taken meanwhile. Other
// commands run at one item per cycle while the output is not stalled. Reset
// clears the controller to disabled, switched off, phase off, level 0, and
// loads the register defaults. When m_axis_tready is low the result holds and
// the queue fills; s_axis_tready drops once it is full.
// ----------------------------------------------------------------------------
`include "led_fade_pulse_controller_core_macros.svh"

module led_fade_pulse_controller_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lfpc_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [lfpc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [2:0] cmd, [12:3] advance_ms, [15:13] zero
  input  logic [lfpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] level, [15:8] pwm_compare, [17:16] phase, [23:18] zero
  output logic [lfpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  logic                              push, pop, div_start;
  lfpc_pkg::item_t                   item_in, item_head;
  lfpc_pkg::queue_stat_t             qstat;
  lfpc_pkg::div_stat_t               div_stat;
  logic [lfpc_pkg::DIV_NUM_W-1:0]    div_num, div_quo;
  logic [lfpc_pkg::DUR_W-1:0]        div_den;

  lfpc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (item_in)
  );

  lfpc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item_in),
    .pop_i  (pop),
    .item_o (item_head),
    .stat_o (qstat)
  );

  lfpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  lfpc_exec u_exec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .item_i        (item_head),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .div_start_o   (div_start),
    .div_num_o     (div_num),
    .div_den_o     (div_den),
    .div_stat_i    (div_stat),
    .div_quo_i     (div_quo),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `LFPC_ASSERT(a_pop_needs_free_out, pop |-> (!m_axis_tvalid || m_axis_tready), "item popped while result stalled")
  `LFPC_ASSERT_NEXT(a_div_runs_after_start, div_start, div_stat.busy, "divider did not start")
  `LFPC_ASSERT(a_pwm_is_complement, m_axis_tvalid |-> ((m_axis_tdata[7:0] ^ m_axis_tdata[15:8]) == 8'hFF), "pwm compare mismatch")

endmodule

// ===== tb/sv/tb_led_fade_pulse_controller_core.sv =====
// ----------------------------------------------------------------------------
// tb_led_fade_pulse_controller_core
// Self-checking bench for the LED fade / pulse controller core.
// ----------------------------------------------------------------------------
// Commands go in on the input stream and each one is run through a software
// copy of the controller. Every output item is checked against the oldest
// prediction. Directed tests cover command decode, soft fades, pulsing holds
// and the spare mode code. A backpressure test fills the block while the
// output is held off. Random traffic then runs with random settings under
// three idle patterns.
// ----------------------------------------------------------------------------
module tb_led_fade_pulse_controller_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIME_BITS   = lfpc_pkg::TIME_BITS;
  localparam int LEVEL_W     = lfpc_pkg::LEVEL_W;
  localparam int DUR_W       = lfpc_pkg::DUR_W;
  localparam int MODE_W      = lfpc_pkg::MODE_W;
  localparam int CMD_W       = lfpc_pkg::CMD_W;
  localparam int ADV_W       = lfpc_pkg::ADV_W;
  localparam int CFG_IDX_W   = lfpc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = lfpc_pkg::CFG_DATA_W;
  localparam int IN_TDATA_W  = lfpc_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = lfpc_pkg::OUT_TDATA_W;

  localparam int                 ELAPSED_MAX = (1 << TIME_BITS) - 1;
  localparam logic [CMD_W-1:0]   CMD_RSVD_6  = 3'd6;
  localparam logic [CMD_W-1:0]   CMD_RSVD_7  = 3'd7;
  localparam logic [MODE_W-1:0]  MODE_SPARE  = 2'd3;
  localparam int                 DRAIN_CYCLES = 40;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] pwm;
    lfpc_pkg::phase_e   phase;
  } lamp_out_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  led_fade_pulse_controller_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // settings copy
  logic [MODE_W-1:0]  lamp_mode     = lfpc_pkg::MODE_RST;
  logic [LEVEL_W-1:0] lamp_on_lvl   = lfpc_pkg::ON_LEVEL_RST;
  logic [LEVEL_W-1:0] lamp_off_lvl  = lfpc_pkg::OFF_LVL_RST;
  logic [DUR_W-1:0]   lamp_fade_in  = lfpc_pkg::FADE_RST;
  logic [DUR_W-1:0]   lamp_fade_out = lfpc_pkg::FADE_RST;
  logic [DUR_W-1:0]   lamp_on_hold  = lfpc_pkg::HOLD_RST;
  logic [DUR_W-1:0]   lamp_off_hold = lfpc_pkg::HOLD_RST;

  // controller state copy
  logic                 lamp_enabled  = 1'b0;
  logic                 lamp_switched = 1'b0;
  lfpc_pkg::phase_e     lamp_phase    = lfpc_pkg::PH_OFF;
  logic [TIME_BITS-1:0] lamp_elapsed  = '0;
  logic [LEVEL_W-1:0]   lamp_level    = '0;

  lamp_out_t pending_outputs[$];
  int        mismatch_count = 0;
  int        items_sent     = 0;
  int        tx_idle_pct    = 0;
  int        rx_idle_pct    = 0;
  int        hold_len       = 0;
  logic      rx_hold        = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [LEVEL_W-1:0] ramp_level(longint t, logic [DUR_W-1:0] dur,
                                                     logic [LEVEL_W-1:0] end_lvl);
    longint on_v;
    longint off_v;
    longint lo;
    longint hi;
    longint v;
    on_v  = longint'(lamp_on_lvl);
    off_v = longint'(lamp_off_lvl);
    lo    = (on_v < off_v) ? on_v : off_v;
    hi    = (on_v < off_v) ? off_v : on_v;
    if (dur == 0) return end_lvl;
    v = off_v + ((on_v - off_v) * t) / longint'(dur);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[LEVEL_W-1:0];
  endfunction

  function automatic logic [LEVEL_W-1:0] fade_in_level();
    return ramp_level(longint'(lamp_elapsed), lamp_fade_in, lamp_on_lvl);
  endfunction

  function automatic logic [LEVEL_W-1:0] fade_out_level();
    return ramp_level(longint'(lamp_fade_out) - longint'(lamp_elapsed), lamp_fade_out,
                      lamp_off_lvl);
  endfunction

  function automatic void advance_brightness();
    case (lamp_mode)
      lfpc_pkg::MODE_NORMAL: begin
        lamp_phase = lamp_switched ? lfpc_pkg::PH_ON : lfpc_pkg::PH_OFF;
        lamp_level = lamp_switched ? lamp_on_lvl : lamp_off_lvl;
      end
      lfpc_pkg::MODE_PULSE: begin
        case (lamp_phase)
          lfpc_pkg::PH_FADE_IN: begin
            lamp_level = fade_in_level();
            if (lamp_elapsed >= lamp_fade_in) begin
              lamp_elapsed = '0;
              lamp_phase   = lfpc_pkg::PH_ON;
            end
          end
          lfpc_pkg::PH_FADE_OUT: begin
            lamp_level = fade_out_level();
            if (lamp_elapsed >= lamp_fade_out) begin
              lamp_level   = lamp_off_lvl;
              lamp_elapsed = '0;
              lamp_phase   = lfpc_pkg::PH_OFF;
            end
          end
          lfpc_pkg::PH_ON: begin
            lamp_level = lamp_on_lvl;
            if (lamp_elapsed >= lamp_on_hold) begin
              lamp_phase   = lfpc_pkg::PH_FADE_OUT;
              lamp_elapsed = '0;
            end
          end
          default: begin
            lamp_level = lamp_off_lvl;
            if (lamp_elapsed >= lamp_off_hold && lamp_switched) begin
              lamp_phase   = lfpc_pkg::PH_FADE_IN;
              lamp_elapsed = '0;
            end
          end
        endcase
      end
      lfpc_pkg::MODE_SOFT: begin
        case (lamp_phase)
          lfpc_pkg::PH_FADE_IN: begin
            lamp_level = fade_in_level();
            if (lamp_level == lamp_on_lvl) begin
              lamp_phase   = lfpc_pkg::PH_ON;
              lamp_elapsed = '0;
            end
          end
          lfpc_pkg::PH_FADE_OUT: begin
            lamp_level = fade_out_level();
            if (lamp_level == lamp_off_lvl) begin
              lamp_phase   = lfpc_pkg::PH_OFF;
              lamp_elapsed = '0;
            end
          end
          lfpc_pkg::PH_ON: begin
            lamp_level = lamp_on_lvl;
            if (!lamp_switched) begin
              lamp_phase   = lfpc_pkg::PH_FADE_OUT;
              lamp_elapsed = '0;
            end
          end
          default: begin
            lamp_level = lamp_off_lvl;
            if (lamp_switched) begin
              lamp_phase   = lfpc_pkg::PH_FADE_IN;
              lamp_elapsed = '0;
            end
          end
        endcase
      end
      default: lamp_level = '0;
    endcase
  endfunction

  function automatic void switch_lamp_off();
    longint fo;
    longint den;
    longint dt;
    if (lamp_phase == lfpc_pkg::PH_ON) begin
      lamp_phase   = lfpc_pkg::PH_FADE_OUT;
      lamp_elapsed = '0;
    end else if (lamp_phase == lfpc_pkg::PH_FADE_IN) begin
      // resume the fade-out from the level the fade-in has reached
      fo  = longint'(lamp_fade_out);
      den = longint'(lamp_on_lvl) - longint'(lamp_off_lvl);
      if (den == 0) dt = fo;
      else dt = fo - (fo * (longint'(lamp_level) - longint'(lamp_off_lvl))) / den;
      if (dt < 0) dt = 0;
      if (dt > fo) dt = fo;
      if (dt > ELAPSED_MAX) dt = ELAPSED_MAX;
      lamp_elapsed = dt[TIME_BITS-1:0];
      lamp_phase   = lfpc_pkg::PH_FADE_OUT;
    end
    lamp_switched = 1'b0;
  endfunction

  function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [ADV_W-1:0] adv);
    int        sum;
    lamp_out_t r;
    case (cmd)
      lfpc_pkg::CMD_TICK: begin
        if (lamp_enabled) begin
          sum          = int'(lamp_elapsed) + int'(adv);
          lamp_elapsed = (sum > ELAPSED_MAX) ? ELAPSED_MAX[TIME_BITS-1:0] : sum[TIME_BITS-1:0];
          advance_brightness();
        end
      end
      lfpc_pkg::CMD_SWITCH_ON: begin
        lamp_elapsed  = '0;
        lamp_switched = 1'b1;
      end
      lfpc_pkg::CMD_SWITCH_OFF: switch_lamp_off();
      lfpc_pkg::CMD_ENABLE: begin
        if (!lamp_enabled) begin
          lamp_enabled = 1'b1;
          lamp_elapsed = '0;
          lamp_phase   = lfpc_pkg::PH_OFF;
        end
      end
      lfpc_pkg::CMD_DISABLE: begin
        if (lamp_enabled) begin
          lamp_enabled = 1'b0;
          lamp_level   = '0;
        end
      end
      default: ;
    endcase
    r.level = lamp_enabled ? lamp_level : '0;
    r.pwm   = lfpc_pkg::LEVEL_FULL - r.level;
    r.phase = lamp_phase;
    pending_outputs.push_back(r);
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      lfpc_pkg::CFG_MODE: begin
        if (data[MODE_W-1:0] != lamp_mode) begin
          lamp_mode    = data[MODE_W-1:0];
          lamp_elapsed = '0;
        end
      end
      lfpc_pkg::CFG_ON_LEVEL: lamp_on_lvl   = data[LEVEL_W-1:0];
      lfpc_pkg::CFG_OFF_LVL:  lamp_off_lvl  = data[LEVEL_W-1:0];
      lfpc_pkg::CFG_FADE_IN:  lamp_fade_in  = data[DUR_W-1:0];
      lfpc_pkg::CFG_FADE_OUT: lamp_fade_out = data[DUR_W-1:0];
      lfpc_pkg::CFG_ON_HOLD:  lamp_on_hold  = data[DUR_W-1:0];
      lfpc_pkg::CFG_OFF_HOLD: lamp_off_hold = data[DUR_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic check_output(logic [OUT_TDATA_W-1:0] data);
    lamp_out_t want;
    if (pending_outputs.size() == 0) begin
      report_mismatch("unexpected item, level", data[7:0], -1);
    end else begin
      want = pending_outputs.pop_front();
      if (data[7:0] !== want.level) report_mismatch("level", data[7:0], want.level);
      if (data[15:8] !== want.pwm) report_mismatch("pwm_compare", data[15:8], want.pwm);
      if (data[17:16] !== want.phase) report_mismatch("phase", data[17:16], want.phase);
    end
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_output(m_axis_tdata);
    if (rx_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // long receiver hold-off, counted here so the sender keeps pushing meanwhile
  initial begin
    forever begin
      wait (hold_len != 0);
      @(posedge clk_i);
      rx_hold <= 1'b1;
      repeat (hold_len) @(posedge clk_i);
      rx_hold <= 1'b0;
      hold_len = 0;
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [ADV_W-1:0] adv);
    // valid is only lowered when a gap is taken, so back-to-back items keep it high
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, adv, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_command(cmd, adv);
    items_sent++;
  endtask

  task automatic wait_idle();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_reg_write(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ADV_W-1:0] rand_adv();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ADV_W'($urandom_range(1023));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_level();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd255;
    return 16'($urandom_range(255));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_ms();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'($urandom_range(65535));
    return 16'($urandom_range(3000));
  endfunction

  // ---------------------------------------------------------------- tests

  // normal mode with reset settings: every command code, disabled behavior
  task automatic test_command_decode();
    send_cmd(lfpc_pkg::CMD_TICK, 10'd1023);
    send_cmd(lfpc_pkg::CMD_SWITCH_ON, 10'd0);
    send_cmd(lfpc_pkg::CMD_SWITCH_OFF, 10'd1023);
    send_cmd(lfpc_pkg::CMD_NOP, 10'd1023);
    send_cmd(CMD_RSVD_6, 10'd0);
    send_cmd(CMD_RSVD_7, 10'd682);
    send_cmd(lfpc_pkg::CMD_ENABLE, 10'd0);
    send_cmd(lfpc_pkg::CMD_ENABLE, 10'd341);
    send_cmd(lfpc_pkg::CMD_TICK, 10'd0);
    send_cmd(lfpc_pkg::CMD_SWITCH_ON, 10'd0);
    send_cmd(lfpc_pkg::CMD_TICK, 10'd1023);
    send_cmd(lfpc_pkg::CMD_DISABLE, 10'd0);
    send_cmd(lfpc_pkg::CMD_DISABLE, 10'd0);
    send_cmd(lfpc_pkg::CMD_TICK, 10'd5);
    wait_idle();
  endtask

  // ramp up, switch off partway through the fade-in, ramp down to the end
  task automatic test_soft_fade();
    write_reg(lfpc_pkg::CFG_MODE, 16'(lfpc_pkg::MODE_SOFT));
    write_reg(lfpc_pkg::CFG_ON_LEVEL, 16'd200);
    write_reg(lfpc_pkg::CFG_OFF_LVL, 16'd10);
    write_reg(lfpc_pkg::CFG_FADE_IN, 16'd400);
    write_reg(lfpc_pkg::CFG_FADE_OUT, 16'd1000);
    send_cmd(lfpc_pkg::CMD_ENABLE, 10'd0);
    send_cmd(lfpc_pkg::CMD_SWITCH_ON, 10'd0);
    send_cmd(lfpc_pkg::CMD_TICK, 10'd5);
    send_cmd(lfpc_pkg::CMD_TICK, 10'd100);
    send_cmd(lfpc_pkg::CMD_SWITCH_OFF, 10'd0);
    send_cmd(lfpc_pkg::CMD_TICK, 10'd1023);
    wait_idle();
  endtask

  // inverted levels, zero fade-out, holds; then the spare mode code
  task automatic test_pulse_holds();
    write_reg(lfpc_pkg::CFG_MODE, 16'(lfpc_pkg::MODE_PULSE));
    write_reg(lfpc_pkg::CFG_ON_LEVEL, 16'd0);
    write_reg(lfpc_pkg::CFG_OFF_LVL, 16'd255);
    write_reg(lfpc_pkg::CFG_FADE_IN, 16'd300);
    write_reg(lfpc_pkg::CFG_FADE_OUT, 16'd0);
    write_reg(lfpc_pkg::CFG_ON_HOLD, 16'd1000);
    write_reg(lfpc_pkg::CFG_OFF_HOLD, 16'd0);
    send_cmd(lfpc_pkg::CMD_SWITCH_ON, 10'd0);
    send_cmd(lfpc_pkg::CMD_TICK, 10'd0);
    send_cmd(lfpc_pkg::CMD_TICK, 10'd1023);
    send_cmd(lfpc_pkg::CMD_TICK, 10'd1023);
    send_cmd(lfpc_pkg::CMD_TICK, 10'd5);
    wait_idle();
    write_reg(lfpc_pkg::CFG_MODE, 16'(MODE_SPARE));
    send_cmd(lfpc_pkg::CMD_TICK, 10'd7);
    wait_idle();
  endtask

  // output held off for a long stretch while items keep coming
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(lfpc_pkg::CFG_MODE, 16'(lfpc_pkg::MODE_SOFT));
    write_reg(lfpc_pkg::CFG_FADE_IN, 16'd2000);
    write_reg(lfpc_pkg::CFG_FADE_OUT, 16'd2000);
    hold_len = 300;
    send_cmd(lfpc_pkg::CMD_SWITCH_ON, 10'd0);
    repeat (8) send_cmd(lfpc_pkg::CMD_TICK, 10'($urandom_range(300)));
    send_cmd(lfpc_pkg::CMD_SWITCH_OFF, 10'd0);
    repeat (8) send_cmd(lfpc_pkg::CMD_TICK, 10'($urandom_range(300)));
    wait_idle();
  endtask

  task automatic run_random_traffic(int n_items);
    int stop_at;
    int kind;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (!lamp_enabled && kind < 85) send_cmd(lfpc_pkg::CMD_ENABLE, rand_adv());
      if (kind < 50) begin
        send_cmd(lfpc_pkg::CMD_SWITCH_ON, rand_adv());
        repeat ($urandom_range(12, 1)) send_cmd(lfpc_pkg::CMD_TICK, rand_adv());
        send_cmd(lfpc_pkg::CMD_SWITCH_OFF, rand_adv());
        repeat ($urandom_range(12, 1)) send_cmd(lfpc_pkg::CMD_TICK, rand_adv());
      end else if (kind < 65) begin
        // catch the lamp early in a fade-in
        send_cmd(lfpc_pkg::CMD_SWITCH_ON, rand_adv());
        repeat ($urandom_range(4, 2))
          send_cmd(lfpc_pkg::CMD_TICK, 10'($urandom_range(200)));
        send_cmd(lfpc_pkg::CMD_SWITCH_OFF, rand_adv());
        repeat ($urandom_range(6, 1)) send_cmd(lfpc_pkg::CMD_TICK, rand_adv());
      end else if (kind < 68) begin
        // long tick run drives the elapsed counter into saturation
        repeat (70) send_cmd(lfpc_pkg::CMD_TICK, 10'($urandom_range(1023, 900)));
      end else if (kind < 85) begin
        repeat ($urandom_range(16, 1)) send_cmd(lfpc_pkg::CMD_TICK, rand_adv());
      end else begin
        send_cmd(CMD_W'($urandom_range(7)), 10'($urandom_range(1023)));
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] on_v;
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      case (p / 4)
        0: begin
          tx_idle_pct = 27;
          rx_idle_pct = 72;
        end
        1: begin
          tx_idle_pct = 72;
          rx_idle_pct = 27;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      on_v = rand_level();
      write_reg(lfpc_pkg::CFG_MODE, (p == 7) ? 16'(MODE_SPARE) : 16'(p % 3));
      write_reg(lfpc_pkg::CFG_ON_LEVEL, on_v);
      write_reg(lfpc_pkg::CFG_OFF_LVL, ($urandom_range(6) == 0) ? on_v : rand_level());
      write_reg(lfpc_pkg::CFG_FADE_IN, rand_ms());
      write_reg(lfpc_pkg::CFG_FADE_OUT, rand_ms());
      write_reg(lfpc_pkg::CFG_ON_HOLD, rand_ms());
      write_reg(lfpc_pkg::CFG_OFF_HOLD, rand_ms());
      run_random_traffic(90);
    end
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    tx_idle_pct = 27;
    rx_idle_pct = 72;
    test_command_decode();
    test_soft_fade();
    test_pulse_holds();
    test_backpressure();
    test_random_traffic();
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
